FILE: hdl/slfr_pkg.sv
// Package for the sync/length/CRC-8 frame receiver.
// Holds shared constants, command/status structs and the CRC-8 byte step.
// No dependencies.
package slfr_pkg;

  localparam int unsigned MIN_LEN   = 3;  // smallest legal length byte
  localparam int unsigned LEN_EXTRA = 2;  // sync + length bytes on top of length

  localparam logic [7:0] SYNC_RST = 8'd200;
  localparam logic [7:0] POLY_RST = 8'd213;

  typedef enum logic [0:0] {
    CFG_SYNC = 1'b0,
    CFG_POLY = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    ACT_BYTE    = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic store_sync;
    logic store_len;
    logic store_data;
    logic clear;
    logic emitting;
  } slfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync_hit;
    logic len_ok;
    logic last_pos;
    logic crc_match;
    logic all_issued;
  } slfr_stat_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ poly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: hdl/slfr_if.sv
// Request channel interfaces for the frame receiver.
// Depends on nothing; input byte channel and frame byte output channel.
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic [6:0] frame_total;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_index, output frame_total,
                  output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input frame_total,
                  input last_byte, output ready);
endinterface

FILE: hdl/slfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/slfr_ctrl.sv
// Frame receiver controller: phase state machine.
// Depends on slfr_pkg; drives datapath commands from its status.
module slfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  input  slfr_pkg::slfr_stat_t stat,
  output slfr_pkg::slfr_cmd_t  cmd
);
  import slfr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LENGTH = 5'b00010,
    ST_DATA   = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_HELD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r != ST_EMIT);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emitting = (state_r == ST_EMIT);
    if (acc && (in_action == ACT_RELEASE)) begin
      cmd.clear = 1'b1;
      state_nxt = ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (acc && stat.sync_hit) begin
            cmd.store_sync = 1'b1;
            state_nxt      = ST_LENGTH;
          end
        end
        ST_LENGTH: begin
          if (acc) begin
            if (stat.len_ok) begin
              cmd.store_len = 1'b1;
              state_nxt     = ST_DATA;
            end else begin
              cmd.clear = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
        ST_DATA: begin
          if (acc) begin
            cmd.store_data = 1'b1;
            if (stat.last_pos) begin
              if (stat.crc_match) begin
                state_nxt = ST_EMIT;
              end else begin
                cmd.clear = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          end
        end
        ST_EMIT: begin
          if (stat.all_issued) state_nxt = ST_HELD;
        end
        ST_HELD: begin
          // bytes ignored until a release
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hdl/slfr_dp.sv
// Frame receiver datapath: config registers, frame store, CRC, readout pipe.
// Depends on slfr_pkg and slfr_ram.
module slfr_dp #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [7:0]           cfg_wdata,
  input  logic [7:0]           byte_value,
  input  slfr_pkg::slfr_cmd_t  cmd,
  output slfr_pkg::slfr_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_frame_byte,
  output logic [5:0]           out_byte_index,
  output logic [6:0]           out_frame_total,
  output logic                 out_last_byte
);
  import slfr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned TW = $clog2(MAX_FRAME_BYTES + 1);

  logic [7:0]    sync_r, poly_r;
  logic [TW-1:0] wp_r, wp_nxt, total_r, total_nxt, rd_cnt_r, rd_cnt_nxt;
  logic [7:0]    crc_r, crc_nxt;

  logic          s1_v_r, s1_last_r;
  logic [TW-1:0] s1_idx_r, s1_total_r;
  logic          out_v_r, out_last_r;
  logic [TW-1:0] out_idx_r, out_total_r;
  logic [7:0]    out_byte_r;

  logic          ram_we, issue, s1_move;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  logic [15:0]   idx_ext, tot_ext;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RST;
      poly_r <= POLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SYNC: sync_r <= cfg_wdata;
        CFG_POLY: poly_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // status
  assign stat.sync_hit   = (byte_value == sync_r);
  assign stat.len_ok     = (9'(byte_value) >= 9'(MIN_LEN)) &&
                           (9'(byte_value) <= 9'(MAX_FRAME_BYTES - LEN_EXTRA));
  assign stat.last_pos   = ((TW+1)'(wp_r) + (TW+1)'(1)) >= (TW+1)'(total_r);
  assign stat.crc_match  = (byte_value == crc_r);
  assign stat.all_issued = (rd_cnt_r == total_r);

  // store write
  always_comb begin
    ram_we    = cmd.store_sync || cmd.store_len || cmd.store_data;
    ram_waddr = wp_r[AW-1:0];
    if (cmd.store_sync)     ram_waddr = AW'(0);
    else if (cmd.store_len) ram_waddr = AW'(1);
  end

  always_comb begin
    wp_nxt     = wp_r;
    total_nxt  = total_r;
    crc_nxt    = crc_r;
    rd_cnt_nxt = rd_cnt_r;
    if (cmd.store_sync) begin
      wp_nxt  = TW'(1);
      crc_nxt = '0;
    end
    if (cmd.store_len) begin
      wp_nxt     = TW'(2);
      total_nxt  = TW'(9'(byte_value) + 9'(LEN_EXTRA));
      crc_nxt    = '0;
      rd_cnt_nxt = '0;
    end
    if (cmd.store_data) begin
      wp_nxt = wp_r + TW'(1);
      if (!stat.last_pos) crc_nxt = crc8_step(crc_r, byte_value, poly_r);
    end
    if (cmd.clear) begin
      wp_nxt    = '0;
      total_nxt = '0;
      crc_nxt   = '0;
    end
    if (issue) rd_cnt_nxt = rd_cnt_r + TW'(1);
  end

  // readout: read issue -> RAM data stage -> output register
  assign s1_move = s1_v_r && (!out_v_r || out_ready);
  assign issue   = cmd.emitting && (rd_cnt_r != total_r) && (!s1_v_r || s1_move);

  slfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_value),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      total_r  <= '0;
      crc_r    <= '0;
      rd_cnt_r <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      total_r  <= total_nxt;
      crc_r    <= crc_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (issue)        s1_v_r <= 1'b1;
      else if (s1_move) s1_v_r <= 1'b0;
      if (s1_move)        out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r   <= rd_cnt_r;
      s1_total_r <= total_r;
      s1_last_r  <= ((TW+1)'(rd_cnt_r) + (TW+1)'(1)) == (TW+1)'(total_r);
    end
    if (s1_move) begin
      out_byte_r  <= ram_rdata;
      out_idx_r   <= s1_idx_r;
      out_total_r <= s1_total_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign idx_ext         = 16'(out_idx_r);
  assign tot_ext         = 16'(out_total_r);
  assign out_valid       = out_v_r;
  assign out_frame_byte  = out_byte_r;
  assign out_byte_index  = idx_ext[5:0];
  assign out_frame_total = tot_ext[6:0];
  assign out_last_byte   = out_last_r;

endmodule

FILE: hdl/sync_length_crc8_frame_receiver_top.sv
// Sync/length/CRC-8 frame receiver. One request (byte or release) per cycle is
// taken in every phase except readout. After a matching CRC byte the frame is
// read out of the frame store at one byte per cycle while the output is not
// stalled, passing the RAM read register and the output register, L+2 bytes in
// all; input is stalled until the last read is issued, which output stalls delay.
// Reset (rst_n low, synchronous): idle, config to sync 200 / poly 213; store not cleared.
module sync_length_crc8_frame_receiver_top #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  slfr_in_if.sink           in_ch,
  slfr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [7:0]        cfg_wdata
);
  import slfr_pkg::*;

  // command/status link between the phase controller and the datapath
  slfr_cmd_t  cmd;
  slfr_stat_t stat;

  // controller owns the phase; in_ready drops only during readout
  slfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: config regs, store, running CRC and the output register
  slfr_dp #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .byte_value      (in_ch.byte_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_frame_byte  (out_ch.frame_byte),
    .out_byte_index  (out_ch.byte_index),
    .out_frame_total (out_ch.frame_total),
    .out_last_byte   (out_ch.last_byte)
  );

endmodule

FILE: tb/sync_length_crc8_frame_receiver_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the sync/length/CRC-8 frame receiver: drives byte and release requests,
// predicts the emitted frame bytes and checks them in order.
// Depends on slfr_pkg, slfr_in_if/slfr_out_if and sync_length_crc8_frame_receiver_top.
module sync_length_crc8_frame_receiver_top_tb;
  import slfr_pkg::*;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned MAX_LEN         = MAX_FRAME_BYTES - LEN_EXTRA;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned STALL_LIMIT     = 1000; // cycles with no request moving on either side

  typedef enum logic [1:0] {RX_IDLE, RX_LENGTH, RX_DATA, RX_HELD} rx_phase_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] val;
  } rx_req_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [5:0] idx;
    logic [6:0] total;
    logic       last;
  } frame_beat_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // channel drive registers, known from time zero
  logic       rx_valid  = 1'b0;
  action_t    rx_action = ACT_BYTE;
  logic [7:0] rx_byte   = 8'h00;
  logic       tx_ready  = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_idx_t   cfg_idx   = CFG_SYNC;
  logic [7:0] cfg_wdata = 8'h00;

  slfr_in_if  in_ch ();
  slfr_out_if out_ch ();

  assign in_ch.valid      = rx_valid;
  assign in_ch.action     = rx_action;
  assign in_ch.byte_value = rx_byte;
  assign out_ch.ready     = tx_ready;

  sync_length_crc8_frame_receiver_top #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Requests waiting to go out, and frame bytes the receiver still owes us
  rx_req_t     pend_q[$];
  frame_beat_t exp_frame_q[$];

  // Receiver state as we believe it to be
  logic [7:0]  cfg_sync = SYNC_RST;
  logic [7:0]  cfg_poly = POLY_RST;
  rx_phase_t   rx_phase = RX_IDLE;
  logic [7:0]  rx_store [MAX_FRAME_BYTES];
  int unsigned rx_wpos  = 0;
  int unsigned rx_total = 0;
  logic [7:0]  rx_crc   = 8'h00;

  int unsigned n_items      = 0;
  int unsigned n_errors     = 0;
  int unsigned rx_gap       = 0;
  int unsigned tx_stall     = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0; // no idling on either side once set

  // CRC-8, MSB first, implicit top bit of the polynomial
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
    return r;
  endfunction

  function automatic void rx_go_idle();
    rx_phase = RX_IDLE;
    rx_wpos  = 0;
    rx_total = 0;
    rx_crc   = 8'h00;
  endfunction

  // Advance the believed state by one accepted request; a CRC hit queues the whole frame.
  task automatic track_rx_request(action_t act, logic [7:0] b);
    frame_beat_t beat;
    if (act == ACT_RELEASE) begin
      rx_go_idle();
      return;
    end
    case (rx_phase)
      RX_IDLE: begin
        if (b == cfg_sync) begin
          rx_store[0] = b;
          rx_wpos     = 1;
          rx_crc      = 8'h00;
          rx_phase    = RX_LENGTH;
        end
      end
      RX_LENGTH: begin
        // a bad length drops back to idle without looking at it as a sync byte
        if (b >= MIN_LEN && b <= MAX_LEN) begin
          rx_store[1] = b;
          rx_wpos     = 2;
          rx_total    = b + LEN_EXTRA;
          rx_crc      = 8'h00;
          rx_phase    = RX_DATA;
        end else begin
          rx_go_idle();
        end
      end
      RX_DATA: begin
        if (rx_wpos >= MAX_FRAME_BYTES || rx_wpos >= rx_total) begin
          rx_go_idle();
        end else begin
          rx_store[rx_wpos] = b;
          rx_wpos++;
          if (rx_wpos >= rx_total) begin
            if (b == rx_crc) begin
              rx_phase = RX_HELD;
              for (int unsigned i = 0; i < rx_total; i++) begin
                beat.fbyte = rx_store[i];
                beat.idx   = i[5:0];
                beat.total = rx_total[6:0];
                beat.last  = (i + 1 == rx_total);
                exp_frame_q.push_back(beat);
              end
            end else begin
              rx_go_idle();
            end
          end else begin
            rx_crc = crc8_next(rx_crc, b, cfg_poly);
          end
        end
      end
      default: ; // held: bytes are dropped until a release
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one request in flight at most, random gap bursts between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_rx
    rx_req_t req;
    logic    nxt_valid;
    nxt_valid = rx_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (rx_valid && in_ch.ready) begin
        track_rx_request(rx_action, rx_byte);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (rx_gap != 0) begin
          rx_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          rx_gap = $urandom_range(0, 3); // start an idle gap of random length
        end else if (pend_q.size() != 0) begin
          req = pend_q.pop_front();
          rx_action <= req.act;
          rx_byte   <= req.val;
          nxt_valid = 1'b1;
        end
      end
    end
    rx_valid <= nxt_valid;
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Frame byte monitor: compares each accepted byte with the oldest expectation,
  // and throttles ready in random stall bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_rx_frames
    frame_beat_t want;
    logic        nxt_ready;
    if (rst_n && out_ch.valid && tx_ready) begin
      if (exp_frame_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected frame byte, expected none, actual byte %0h index %0d",
                 $time, out_ch.frame_byte, out_ch.byte_index);
      end else begin
        want = exp_frame_q.pop_front();
        check_field("frame_byte", want.fbyte, out_ch.frame_byte);
        check_field("byte_index", want.idx, out_ch.byte_index);
        check_field("frame_total", want.total, out_ch.frame_total);
        check_field("last_byte", want.last, out_ch.last_byte);
      end
    end
    if (tx_stall != 0) begin
      tx_stall--;
      nxt_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      tx_stall  = $urandom_range(0, 3);
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    tx_ready <= nxt_ready;
  end

  // Watchdog: too long with no request moving on either channel ends the run
  always @(posedge clk) begin : watchdog
    if (!rst_n || (rx_valid && in_ch.ready) || (out_ch.valid && tx_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(action_t a, logic [7:0] v, bit counted);
    rx_req_t r;
    r.act = a;
    r.val = v;
    pend_q.push_back(r);
    if (counted) n_items++;
  endtask

  task automatic push_release();
    push_req(ACT_RELEASE, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Frame with length byte len; only the first cut bytes go out. A bad frame gets a
  // corrupted CRC byte. Sync values turn up inside the body now and then.
  task automatic push_frame(int unsigned len, bit good, int unsigned cut, bit with_sync);
    logic [7:0] body[$];
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'h00;
    body.push_back(cfg_sync);
    body.push_back(len[7:0]);
    for (int unsigned i = 0; i + 1 < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if ((with_sync && i == 1) || $urandom_range(0, 15) == 0) b = cfg_sync;
      crc = crc8_next(crc, b, cfg_poly);
      body.push_back(b);
    end
    body.push_back(good ? crc : crc ^ 8'($urandom_range(1, 255)));
    foreach (body[i]) if (i < cut) push_req(ACT_BYTE, body[i], 1'b1);
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise
  task automatic push_random(int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = n_items;
    while (n_items - start < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) len = MAX_LEN;
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(MIN_LEN, MAX_LEN);
      else len = $urandom_range(MIN_LEN, 10);
      if (pick < 60) begin
        push_frame(len, 1'b1, len + LEN_EXTRA, 1'b0);
        // bytes landing while held are dropped; they do not count as stimulus
        repeat ($urandom_range(0, 2)) push_req(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        push_release();
      end else if (pick < 70) begin
        push_frame(len, 1'b0, len + LEN_EXTRA, 1'b0);
      end else if (pick < 78) begin
        push_req(ACT_BYTE, cfg_sync, 1'b1);
        if ($urandom_range(0, 1) == 0) push_req(ACT_BYTE, 8'($urandom_range(0, MIN_LEN - 1)), 1'b1);
        else push_req(ACT_BYTE, 8'($urandom_range(MAX_LEN + 1, 255)), 1'b1);
      end else if (pick < 86) begin
        push_frame(len, 1'b1, $urandom_range(1, len + 1), 1'b0);
        push_release();
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 4)) push_req(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b1);
        push_release();
      end else begin
        push_release();
      end
    end
  endtask

  // Sender holds off until every request has gone and every frame byte has come back,
  // then lets the receiver finish anything that produces no output.
  task automatic settle();
    while (pend_q.size() != 0 || rx_valid || exp_frame_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC: cfg_sync = val;
      CFG_POLY: cfg_poly = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings
    push_release();                                   // release with nothing held
    push_frame(MIN_LEN, 1'b1, MIN_LEN + LEN_EXTRA, 1'b0); // shortest frame
    push_req(ACT_BYTE, 8'hA5, 1'b1);                  // dropped while held
    push_release();
    push_req(ACT_BYTE, cfg_sync, 1'b1);               // length just too short
    push_req(ACT_BYTE, 8'(MIN_LEN - 1), 1'b1);
    push_req(ACT_BYTE, cfg_sync, 1'b1);               // sync as length: bad, not a new start
    push_req(ACT_BYTE, cfg_sync, 1'b1);
    push_frame(4, 1'b1, 4 + LEN_EXTRA, 1'b1);         // sync value inside the payload
    push_release();
    push_frame(MIN_LEN, 1'b0, MIN_LEN + LEN_EXTRA, 1'b0); // CRC mismatch, silent
    push_frame(5, 1'b1, 4, 1'b0);                     // release part way through
    push_release();
    push_frame(MAX_LEN, 1'b1, MAX_LEN + LEN_EXTRA, 1'b0); // longest frame
    push_release();
    push_random(40);
    push_release();
    settle();

    // Both registers at their low extreme
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_POLY, 8'h00);
    push_random(65);
    push_release();
    settle();

    // High extreme
    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_POLY, 8'hFF);
    push_random(65);
    push_release();
    settle();

    write_reg(CFG_SYNC, 8'($urandom_range(0, 255)));
    write_reg(CFG_POLY, 8'($urandom_range(0, 255)));
    push_random(65);
    push_release();
    settle();

    // Last stretch at full rate on both sides
    calm = 1'b1;
    write_reg(CFG_SYNC, 8'h7E);
    write_reg(CFG_POLY, 8'h07);
    push_random(65);
    push_release();
    settle();

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
